@@ hw/rtl/dfbo_pkg.sv @@
`default_nettype none

package dfbo_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = IDX_W + 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic load;
        logic rd_blk_i;
        logic rd_blk_p;
        logic begin_walk;
        logic push;
        logic step_walk;
        logic rd_stack;
        logic rd_em;
        logic clr_em;
        logic emit_ident;
        logic emit_b;
        logic emit_i;
        logic next_i;
        logic clr_i;
    } dfbo_cmd_t;

    typedef struct packed {
        logic set_end;
        logic needs_now;
        logic i_last;
        logic i_max;
        logic k_last;
        logic rd_reach;
        logic emitted;
        logic walk_stop;
        logic depth_zero;
        logic slot_free;
    } dfbo_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/dfbo_ram.sv @@
`default_nettype none

module dfbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dfbo_ctrl.sv @@
`default_nettype none

module dfbo_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire dfbo_pkg::dfbo_status_t status,
    output dfbo_pkg::dfbo_cmd_t        cmd
);

    import dfbo_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_LOAD,
        S_IDENT,
        S_CHK_RD,
        S_CHK,
        S_PUSH,
        S_WALK_RD,
        S_POP,
        S_POP_RD,
        S_POP_EMIT,
        S_UN_RD,
        S_UN_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_em = 1'b1;
                if (status.i_max)
                begin
                    cmd.clr_i  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                end
            end
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.set_end)
                    begin
                        state_next = status.needs_now ? S_CHK_RD : S_IDENT;
                    end
                end
            end
            S_IDENT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_ident = 1'b1;
                    if (status.k_last)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_CHK_RD:
            begin
                cmd.rd_blk_i = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (!status.rd_reach || status.emitted)
                begin
                    if (status.i_last)
                    begin
                        cmd.clr_i  = 1'b1;
                        state_next = S_UN_RD;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = S_CHK_RD;
                    end
                end
                else
                begin
                    cmd.begin_walk = 1'b1;
                    state_next     = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (status.emitted)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.push = 1'b1;
                    if (status.walk_stop)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        cmd.rd_blk_p = 1'b1;
                        state_next   = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                if (!status.rd_reach)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.step_walk = 1'b1;
                    state_next    = S_PUSH;
                end
            end
            S_POP:
            begin
                if (status.depth_zero)
                begin
                    if (status.i_last)
                    begin
                        cmd.clr_i  = 1'b1;
                        state_next = S_UN_RD;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = S_CHK_RD;
                    end
                end
                else
                begin
                    cmd.rd_stack = 1'b1;
                    state_next   = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_em  = 1'b1;
                state_next = S_POP_EMIT;
            end
            S_POP_EMIT:
            begin
                if (status.emitted)
                begin
                    state_next = S_POP;
                end
                else if (status.slot_free)
                begin
                    cmd.emit_b = 1'b1;
                    state_next = S_POP;
                end
            end
            S_UN_RD:
            begin
                cmd.rd_blk_i = 1'b1;
                cmd.clr_em   = 1'b1;
                state_next   = S_UN_CHK;
            end
            S_UN_CHK:
            begin
                if (status.rd_reach || status.slot_free)
                begin
                    cmd.emit_i = !status.rd_reach;
                    if (status.i_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = S_UN_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dfbo_dp.sv @@
`default_nettype none

module dfbo_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  reachable,
    input  wire dfbo_pkg::idx_t        dominator_index,
    input  wire logic                  is_last,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output dfbo_pkg::idx_t             order_index,
    output logic                       reordered,
    output logic                       last_out,
    input  wire dfbo_pkg::dfbo_cmd_t   cmd,
    output dfbo_pkg::dfbo_status_t     status
);

    import dfbo_pkg::*;

    idx_t                  pos_reg;
    cnt_t                  n_reg;
    idx_t                  i_reg;
    idx_t                  k_reg;
    idx_t                  a_reg;
    idx_t                  par_reg;
    cnt_t                  depth_reg;
    cnt_t                  depth_m1;
    logic                  saw_reg;
    logic                  needs_reg;
    logic                  out_valid_reg;
    idx_t                  order_index_reg;
    logic                  reordered_reg;
    logic                  last_out_reg;

    logic [IDX_W:0] blk_rdata;
    logic           rd_reach;
    idx_t           rd_par;
    idx_t           stk_b;
    logic           em_we;
    idx_t           em_waddr;
    logic           em_re;
    idx_t           em_raddr;
    logic           em_rdata;
    logic           item_needs;
    logic           emit_any;
    idx_t           emit_idx;
    logic           slot_free;
    logic           k_last;

    dfbo_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (pos_reg),
        .wdata ({reachable, dominator_index}),
        .re    (cmd.rd_blk_i || cmd.rd_blk_p),
        .raddr (cmd.rd_blk_p ? par_reg : i_reg),
        .rdata (blk_rdata)
    );

    assign depth_m1 = depth_reg - 1'b1;

    dfbo_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (depth_reg[IDX_W-1:0]),
        .wdata (a_reg),
        .re    (cmd.rd_stack),
        .raddr (depth_m1[IDX_W-1:0]),
        .rdata (stk_b)
    );

    assign em_we    = cmd.emit_b || cmd.clr_em;
    assign em_waddr = cmd.emit_b ? stk_b : i_reg;
    assign em_re    = cmd.rd_blk_i || cmd.rd_blk_p || cmd.rd_em;
    assign em_raddr = cmd.rd_blk_p ? par_reg : (cmd.rd_em ? stk_b : i_reg);

    dfbo_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_emit_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (cmd.emit_b),
        .re    (em_re),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    assign rd_reach   = blk_rdata[IDX_W];
    assign rd_par     = blk_rdata[IDX_W-1:0];
    assign item_needs = reachable && (saw_reg || (dominator_index > pos_reg));
    assign emit_any   = cmd.emit_ident || cmd.emit_b || cmd.emit_i;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign k_last     = ({1'b0, k_reg} == (n_reg - 1'b1));

    always_comb
    begin
        if (cmd.emit_ident)
        begin
            emit_idx = k_reg;
        end
        else if (cmd.emit_b)
        begin
            emit_idx = stk_b;
        end
        else
        begin
            emit_idx = i_reg;
        end
    end

    assign status.set_end    = is_last || (pos_reg == IDX_W'(MAX_BLOCKS - 1));
    assign status.needs_now  = (needs_reg || item_needs) && (pos_reg != '0);
    assign status.i_last     = ({1'b0, i_reg} == (n_reg - 1'b1));
    assign status.i_max      = (i_reg == IDX_W'(MAX_BLOCKS - 1));
    assign status.k_last     = k_last;
    assign status.rd_reach   = rd_reach;
    assign status.emitted    = em_rdata;
    assign status.walk_stop  = (a_reg == '0) || ((depth_reg + 1'b1) >= n_reg)
                               || ({1'b0, par_reg} >= n_reg);
    assign status.depth_zero = (depth_reg == '0);
    assign status.slot_free  = slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            a_reg         <= '0;
            par_reg       <= '0;
            depth_reg     <= '0;
            saw_reg       <= 1'b0;
            needs_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (status.set_end)
                begin
                    n_reg     <= {1'b0, pos_reg} + 1'b1;
                    pos_reg   <= '0;
                    saw_reg   <= 1'b0;
                    needs_reg <= 1'b0;
                    i_reg     <= '0;
                    k_reg     <= '0;
                end
                else
                begin
                    pos_reg   <= pos_reg + 1'b1;
                    saw_reg   <= saw_reg || !reachable;
                    needs_reg <= needs_reg || item_needs;
                end
            end
            if (cmd.next_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
            else if (cmd.clr_i)
            begin
                i_reg <= '0;
            end
            if (cmd.begin_walk)
            begin
                a_reg     <= i_reg;
                par_reg   <= rd_par;
                depth_reg <= '0;
            end
            else if (cmd.step_walk)
            begin
                a_reg   <= par_reg;
                par_reg <= rd_par;
            end
            if (cmd.push)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            else if (cmd.rd_stack)
            begin
                depth_reg <= depth_m1;
            end
            if (emit_any)
            begin
                out_valid_reg <= 1'b1;
                k_reg         <= k_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            order_index_reg <= emit_idx;
            reordered_reg   <= !cmd.emit_ident;
            last_out_reg    <= k_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign order_index = order_index_reg;
    assign reordered   = reordered_reg;
    assign last_out    = last_out_reg;

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> slot_free)
        else $error("Result register overwritten before transfer.");

    a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_b |-> !em_rdata)
        else $error("Block emitted twice.");

    a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (depth_reg < n_reg))
        else $error("Pending stack overflow.");

    a_unreach_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_i |-> !rd_reach)
        else $error("Reachable block emitted in the unreachable pass.");

endmodule

`default_nettype wire

@@ hw/rtl/dominator_first_block_order_top.sv @@
// Loads a set of up to 64 blocks, one block per input transfer (entry block first), and after
// the block flagged is_last (or the 64th) emits one result per block of the set: the identity
// order when no reorder is needed, otherwise reachable blocks with their not-yet-emitted
// dominator ancestors pulled ahead, then the unreachable blocks in index order. Input is
// stalled from the end of a set until its last result has been produced, and after reset while
// the emitted flags are cleared. The identity order emits a result whenever the output register
// is free; a reordered set reads and checks each block in a scan, pushes and reads the parent
// for each ancestor step, reads the stack and the emitted flag before each pop's emit, and
// makes one more pass over the blocks for the unreachable ones, which also clears the emitted
// flags, each step bound by the single read port of the block, stack and emitted-flag memories.
`default_nettype none

module dominator_first_block_order_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           reachable,
    input  wire dfbo_pkg::idx_t dominator_index,
    input  wire logic           is_last,
    output logic                out_valid,
    input  wire logic           out_stall,
    output dfbo_pkg::idx_t      order_index,
    output logic                reordered,
    output logic                last_out
);

    import dfbo_pkg::*;

    dfbo_cmd_t    cmd;
    dfbo_status_t status;

    dfbo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dfbo_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .reachable       (reachable),
        .dominator_index (dominator_index),
        .is_last         (is_last),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .order_index     (order_index),
        .reordered       (reordered),
        .last_out        (last_out),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire
